FILE: src/ppp_pkg.sv
package ppp_pkg;

   localparam int MAX_PLANES      = 8;
   localparam int PLANE_WORDS     = 8;
   localparam int PALETTE_ENTRIES = 256;
   localparam int ENTRY_W         = 32;
   localparam int INDEX_W         = $clog2(PALETTE_ENTRIES);
   localparam int COLUMN_PIXELS   = 16;
   localparam int PIX_CNT_W       = $clog2(COLUMN_PIXELS);
   localparam int CSR_DATA_W      = 4;

   localparam logic [INDEX_W-1:0]   REMAP_INDEX = INDEX_W'(PALETTE_ENTRIES - 1);
   localparam logic [PIX_CNT_W-1:0] LAST_PIXEL  = PIX_CNT_W'(COLUMN_PIXELS - 1);

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_CONVERT = 1'b1;

   localparam logic CSR_SOURCE_PLANES   = 1'b0;
   localparam logic CSR_BYTES_PER_PIXEL = 1'b1;

   typedef struct packed {
      logic        func;
      logic [7:0]  entry_index;
      logic [31:0] entry_value;
      logic [15:0] plane_word_0;
      logic [15:0] plane_word_1;
      logic [15:0] plane_word_2;
      logic [15:0] plane_word_3;
      logic [15:0] plane_word_4;
      logic [15:0] plane_word_5;
      logic [15:0] plane_word_6;
      logic [15:0] plane_word_7;
      logic        last_column;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] pixel_value;
      logic        last_pixel;
      logic        end_of_image;
   } rsp_payload_type;

   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] addr;
      logic               last_pixel;
      logic               end_of_image;
   } rd_req_type;

   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] addr;
      logic [ENTRY_W-1:0] data;
   } wr_req_type;

   typedef struct packed {
      logic               valid;
      logic [ENTRY_W-1:0] data;
      logic               last_pixel;
      logic               end_of_image;
   } rd_rsp_type;

   // Bits of the palette index that the configured plane count uses.
   function automatic logic [PLANE_WORDS-1:0] plane_mask(input logic [3:0] planes);
      logic [PLANE_WORDS-1:0] mask;
      for (int n = 0; n < PLANE_WORDS; n++) begin
         mask[n] = (planes > 4'(n));
      end
      return mask;
   endfunction

   // Keep the leading bytes of the entry, right-justified.
   function automatic logic [31:0] pack_pixel(input logic [ENTRY_W-1:0] entry,
                                              input logic [2:0] bytes);
      logic [31:0] pix;
      priority if (bytes <= 3'd2) begin
         pix = {16'h0000, entry[31:16]};
      end else if (bytes == 3'd3) begin
         pix = {8'h00, entry[31:8]};
      end else begin
         pix = entry;
      end
      return pix;
   endfunction

endpackage

FILE: src/ppp_palette_mem.sv
module ppp_palette_mem
   import ppp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  wr_req_type wr_req,
   input  rd_req_type rd_req,
   output rd_rsp_type rd_rsp
);

   logic [ENTRY_W-1:0] mem [PALETTE_ENTRIES];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_valid_ff;
   logic               rd_last_ff;
   logic               rd_end_ff;

   // Read returns the old contents when a write hits the same entry.
   always_ff @(posedge clock) begin
      if (wr_req.valid) begin
         mem[wr_req.addr] <= wr_req.data;
      end
      if (rd_req.valid) begin
         rd_data_ff <= mem[rd_req.addr];
         rd_last_ff <= rd_req.last_pixel;
         rd_end_ff  <= rd_req.end_of_image;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_req.valid;
      end
   end

   assign rd_rsp.valid        = rd_valid_ff;
   assign rd_rsp.data         = rd_data_ff;
   assign rd_rsp.last_pixel   = rd_last_ff;
   assign rd_rsp.end_of_image = rd_end_ff;

   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      rd_req.valid && rd_req.end_of_image |-> rd_req.last_pixel)
      else $error("end_of_image read without last_pixel");

endmodule

FILE: src/ppp_sequencer.sv
module ppp_sequencer
   import ppp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_data,
   input  logic [PLANE_WORDS-1:0] index_mask,
   input  logic                   remap_en,
   input  logic                   issue_ok,
   output rd_req_type             rd_req,
   output wr_req_type             wr_req
);

   logic                   busy_ff, busy_in;
   logic [PIX_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [15:0]            words_ff [PLANE_WORDS];
   logic [15:0]            words_in [PLANE_WORDS];
   logic                   last_col_ff, last_col_in;
   logic [15:0]            req_words [PLANE_WORDS];
   logic [PLANE_WORDS-1:0] raw_index;
   logic [PLANE_WORDS-1:0] used_index;
   logic [INDEX_W-1:0]     rd_index;
   logic                   issue;
   logic                   accept;
   logic                   on_last;

   assign req_words[0] = req_data.plane_word_0;
   assign req_words[1] = req_data.plane_word_1;
   assign req_words[2] = req_data.plane_word_2;
   assign req_words[3] = req_data.plane_word_3;
   assign req_words[4] = req_data.plane_word_4;
   assign req_words[5] = req_data.plane_word_5;
   assign req_words[6] = req_data.plane_word_6;
   assign req_words[7] = req_data.plane_word_7;

   assign issue     = busy_ff && issue_ok;
   assign on_last   = (cnt_ff == LAST_PIXEL);
   assign req_stall = busy_ff && !(issue && on_last);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      for (int n = 0; n < PLANE_WORDS; n++) begin
         raw_index[n] = words_ff[n][15];
      end
      used_index = raw_index & index_mask;
      if (remap_en && (used_index == index_mask)) begin
         rd_index = REMAP_INDEX;
      end else begin
         rd_index = INDEX_W'(used_index);
      end
   end

   always_comb begin
      busy_in     = busy_ff;
      cnt_in      = cnt_ff;
      words_in    = words_ff;
      last_col_in = last_col_ff;
      if (issue) begin
         cnt_in = cnt_ff + PIX_CNT_W'(1);
         for (int n = 0; n < PLANE_WORDS; n++) begin
            words_in[n] = {words_ff[n][14:0], 1'b0};
         end
         if (on_last) begin
            busy_in = 1'b0;
         end
      end
      if (accept && (req_data.func == FUNC_CONVERT)) begin
         busy_in     = 1'b1;
         cnt_in      = '0;
         words_in    = req_words;
         last_col_in = req_data.last_column;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff    <= words_in;
      last_col_ff <= last_col_in;
   end

   assign rd_req.valid        = issue;
   assign rd_req.addr         = rd_index;
   assign rd_req.last_pixel   = on_last;
   assign rd_req.end_of_image = on_last && last_col_ff;

   assign wr_req.valid = accept && (req_data.func == FUNC_LOAD);
   assign wr_req.addr  = req_data.entry_index;
   assign wr_req.data  = req_data.entry_value;

   a_convert_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.func == FUNC_CONVERT) |=> busy_ff && (cnt_ff == '0))
      else $error("convert request did not start a column");

   a_hold_mid_column: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !on_last |-> req_stall)
      else $error("request taken in the middle of a column");

endmodule

FILE: src/ppp_out_buffer.sv
module ppp_out_buffer
   import ppp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  rd_rsp_type      rd_rsp,
   input  logic [2:0]      bytes_eff,
   output logic            issue_ok,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   rsp_payload_type buf_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   logic            push;
   logic            pop;
   logic [2:0]      occupancy;
   rsp_payload_type push_item;

   assign push = rd_rsp.valid;
   assign pop  = rsp_valid && !rsp_stall;

   assign push_item.pixel_value  = pack_pixel(rd_rsp.data, bytes_eff);
   assign push_item.last_pixel   = rd_rsp.last_pixel;
   assign push_item.end_of_image = rd_rsp.end_of_image;

   // Allow a read only if its data will find a free slot when the memory returns it.
   assign occupancy = {1'b0, count_ff} + {2'b00, push};
   assign issue_ok  = (occupancy < (3'd2 + {2'b00, pop}));

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = buf_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2) || pop)
      else $error("pixel pushed into a full buffer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("buffer count out of range");

endmodule

FILE: src/planar_to_packed_palette.sv
// Channel  Direction  Handshake              Payload
// req_     in         req_valid / req_stall  req_payload_type (load or convert)
// rsp_     out        rsp_valid / rsp_stall  rsp_payload_type (one pixel)
// csr_     in         csr_valid / csr_ready  csr_index, csr_wdata
//
// A load request writes one palette entry; a convert request makes 16 palette
// reads, one per pixel, on the single read port of the palette memory.
// A pixel passes the memory read register, then the output buffer, after its read is issued.
// Reset clears control state only; palette contents stay undefined until loaded.
// A stall on rsp_ holds the reads once the two-entry output buffer is committed.
module planar_to_packed_palette
   import ppp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [3:0]             source_planes_ff, source_planes_in;
   logic [2:0]             bytes_per_pixel_ff, bytes_per_pixel_in;
   logic [3:0]             planes_eff;
   logic [PLANE_WORDS-1:0] index_mask;
   logic                   remap_en;
   logic                   issue_ok;
   rd_req_type             rd_req;
   wr_req_type             wr_req;
   rd_rsp_type             rd_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      source_planes_in   = source_planes_ff;
      bytes_per_pixel_in = bytes_per_pixel_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SOURCE_PLANES:   source_planes_in   = csr_wdata[3:0];
            CSR_BYTES_PER_PIXEL: bytes_per_pixel_in = csr_wdata[2:0];
            default:             source_planes_in   = source_planes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_planes_ff   <= 4'd4;
         bytes_per_pixel_ff <= 3'd2;
      end else begin
         source_planes_ff   <= source_planes_in;
         bytes_per_pixel_ff <= bytes_per_pixel_in;
      end
   end

   // Saturate the plane count; below a full byte the all-ones index maps to the last entry.
   assign planes_eff = (source_planes_ff > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : source_planes_ff;
   assign index_mask = plane_mask(planes_eff);
   assign remap_en   = (planes_eff < 4'(PLANE_WORDS));

   ppp_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .index_mask (index_mask),
      .remap_en   (remap_en),
      .issue_ok   (issue_ok),
      .rd_req     (rd_req),
      .wr_req     (wr_req)
   );

   ppp_palette_mem u_palette_mem (
      .clock  (clock),
      .reset  (reset),
      .wr_req (wr_req),
      .rd_req (rd_req),
      .rd_rsp (rd_rsp)
   );

   ppp_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .rd_rsp    (rd_rsp),
      .bytes_eff (bytes_per_pixel_ff),
      .issue_ok  (issue_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sim/planar_to_packed_palette_tb.sv
module planar_to_packed_palette_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ppp_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 4;
   localparam int DRAIN_CYCLES = 16;
   localparam int END_CYCLES   = 50;
   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_STRETCH = 150;
   localparam int PHASE_ITEMS  = 28;

   class pixel_scoreboard;
      logic [ENTRY_W-1:0] palette [PALETTE_ENTRIES];
      bit                 written [PALETTE_ENTRIES];
      logic [3:0]         source_planes;
      logic [2:0]         bytes_per_pixel;
      rsp_payload_type    expected_pixels [$];
      int                 errors;

      function new();
         source_planes   = 4'd4;
         bytes_per_pixel = 3'd2;
         errors          = 0;
         foreach (written[i]) begin
            written[i] = 1'b0;
            palette[i] = '0;
         end
      endfunction

      function int planes_used();
         return (source_planes > 4'(MAX_PLANES)) ? MAX_PLANES : int'(source_planes);
      endfunction

      function int bytes_kept();
         if (bytes_per_pixel < 3'd2) return 2;
         if (bytes_per_pixel > 3'd4) return 4;
         return int'(bytes_per_pixel);
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      task report_mismatch(input string msg);
         $display("ERROR at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function void write_register(input logic idx, input logic [CSR_DATA_W-1:0] wdata);
         if (idx == CSR_SOURCE_PLANES) begin
            source_planes = wdata;
         end else begin
            bytes_per_pixel = wdata[2:0];
         end
      endfunction

      // A load fills one entry; a convert queues its sixteen pixels.
      function void note_request(input req_payload_type r);
         logic [15:0]     words [PLANE_WORDS];
         logic [7:0]      slot;
         logic [7:0]      all_ones;
         rsp_payload_type pix;
         int              p;
         int              b;
         if (r.func == FUNC_LOAD) begin
            palette[r.entry_index] = r.entry_value;
            written[r.entry_index] = 1'b1;
            return;
         end
         p = planes_used();
         b = bytes_kept();
         words = '{r.plane_word_0, r.plane_word_1, r.plane_word_2, r.plane_word_3,
                   r.plane_word_4, r.plane_word_5, r.plane_word_6, r.plane_word_7};
         all_ones = 8'((1 << p) - 1);
         for (int k = 0; k < COLUMN_PIXELS; k++) begin
            slot = '0;
            for (int n = 0; n < p; n++) slot[n] = words[n][15-k];
            if (p < MAX_PLANES && slot == all_ones) slot = REMAP_INDEX;
            pix.pixel_value  = palette[slot] >> (8 * (4 - b));
            pix.last_pixel   = (k == COLUMN_PIXELS - 1);
            pix.end_of_image = pix.last_pixel && r.last_column;
            expected_pixels.push_back(pix);
         end
      endfunction

      task check_pixel(input rsp_payload_type got);
         rsp_payload_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("pixel %h with none pending", got.pixel_value));
            return;
         end
         want = expected_pixels.pop_front();
         if (got.pixel_value !== want.pixel_value)
            report_mismatch($sformatf("pixel_value got %h want %h",
                                      got.pixel_value, want.pixel_value));
         if (got.last_pixel !== want.last_pixel)
            report_mismatch($sformatf("last_pixel got %b want %b",
                                      got.last_pixel, want.last_pixel));
         if (got.end_of_image !== want.end_of_image)
            report_mismatch($sformatf("end_of_image got %b want %b",
                                      got.end_of_image, want.end_of_image));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_payload_type       rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pixel_scoreboard board = new();
   bit              idle_on = 1'b1;
   int              hold_cycles = 0;
   int              quiet_cycles = 0;

   planar_to_packed_palette dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Register writes first, then requests, then pixels: keeps the prediction in order.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.write_register(csr_index, csr_wdata);
         if (req_valid && !req_stall) board.note_request(req_data);
         if (rsp_valid && !rsp_stall) board.check_pixel(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("planar_to_packed_palette test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : pixel_sink
      int wait_cycles;
      rsp_stall = 1'b0;
      forever begin
         if (hold_cycles > 0) begin
            wait_cycles = hold_cycles;
            hold_cycles = 0;
         end else begin
            wait_cycles = idle_on ? $urandom_range(0, 5) : 0;
         end
         repeat (wait_cycles) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_request(input req_payload_type r);
      int gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid, let every pixel out, then give a trailing load time to land.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_register(input logic idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [3:0] planes, input logic [2:0] bytes);
      settle();
      set_register(CSR_SOURCE_PLANES, planes);
      set_register(CSR_BYTES_PER_PIXEL, {1'($urandom), bytes});
   endtask

   function automatic req_payload_type make_load(input logic [7:0] slot,
                                                 input logic [31:0] value);
      req_payload_type r;
      r = req_payload_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      r.func        = FUNC_LOAD;
      r.entry_index = slot;
      r.entry_value = value;
      return r;
   endfunction

   function automatic req_payload_type make_plain_column(input logic [15:0] w0,
                                                         input logic [15:0] w1,
                                                         input logic [15:0] w2,
                                                         input logic [15:0] w3,
                                                         input bit last_col);
      req_payload_type r;
      r = req_payload_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      r.func         = FUNC_CONVERT;
      r.plane_word_0 = w0;
      r.plane_word_1 = w1;
      r.plane_word_2 = w2;
      r.plane_word_3 = w3;
      r.last_column  = last_col;
      return r;
   endfunction

   // Pick each pixel's index among loaded entries; unused planes stay random.
   function automatic req_payload_type make_column(input bit last_col);
      req_payload_type r;
      logic [15:0]     words [PLANE_WORDS];
      logic [7:0]      v;
      logic [7:0]      slot;
      logic [7:0]      all_ones;
      int              p;
      int              tries;
      p = board.planes_used();
      all_ones = 8'((1 << p) - 1);
      foreach (words[n]) words[n] = 16'($urandom);
      for (int k = 0; k < COLUMN_PIXELS; k++) begin
         tries = 0;
         do begin
            v = ($urandom_range(0, 3) == 0) ? all_ones : (8'($urandom) & all_ones);
            slot = (p < MAX_PLANES && v == all_ones) ? REMAP_INDEX : v;
            tries++;
         end while (!board.written[slot] && tries < 8);
         // Entries 0 and 255 are loaded first, so index zero is always safe.
         if (!board.written[slot]) v = '0;
         for (int n = 0; n < p; n++) words[n][15-k] = v[n];
      end
      r.func         = FUNC_CONVERT;
      r.entry_index  = 8'($urandom);
      r.entry_value  = $urandom;
      r.plane_word_0 = words[0];
      r.plane_word_1 = words[1];
      r.plane_word_2 = words[2];
      r.plane_word_3 = words[3];
      r.plane_word_4 = words[4];
      r.plane_word_5 = words[5];
      r.plane_word_6 = words[6];
      r.plane_word_7 = words[7];
      r.last_column  = last_col;
      return r;
   endfunction

   initial begin : stimulus
      logic [3:0] phase_planes [10];
      logic [2:0] phase_bytes  [10];
      phase_planes = '{4'd4, 4'd8, 4'd2, 4'd6, 4'd3, 4'd5, 4'd7, 4'd0, 4'd1, 4'd12};
      phase_bytes  = '{3'd2, 3'd4, 3'd3, 3'd4, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd6};
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes of the palette, remap of the all-ones index, ignored fields.
      send_request(make_load(8'hFF, 32'hFFFF_FFFF));
      send_request(make_load(8'h00, $urandom));
      for (int i = 1; i < 14; i++) send_request(make_load(8'(i), $urandom));
      send_request(make_load(8'd14, 32'h0000_0000));
      send_request(make_plain_column(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
      send_request(make_plain_column(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
      send_request(make_plain_column(16'hAAAA, 16'hCCCC, 16'hF0F0, 16'hFF00, 1'b1));
      send_request(make_load(8'h80, $urandom));
      configure(4'd8, 3'd4);
      send_request(make_column(1'b1));
      configure(4'd0, 3'd3);
      send_request(make_column(1'b0));
      configure(4'd15, 3'd7);
      send_request(make_column(1'b1));
      configure(4'd1, 3'd0);
      send_request(make_column(1'b0));
      configure(4'd7, 3'd1);
      send_request(make_column(1'b1));

      for (int phase = 0; phase < 10; phase++) begin
         configure(phase_planes[phase], phase_bytes[phase]);
         idle_on = (phase % 4 != 1);
         // Hold the pixel side off so the block backs up onto its input.
         if (phase == 3) hold_cycles = HOLD_STRETCH;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 35) begin
               send_request(make_load(8'($urandom), $urandom));
            end else begin
               send_request(make_column($urandom_range(0, 3) == 0));
            end
         end
      end
      idle_on = 1'b1;

      settle();
      repeat (END_CYCLES) @(posedge clock);
      if (board.pending() != 0)
         board.report_mismatch($sformatf("%0d pixels never arrived", board.pending()));
      if (board.errors == 0) begin
         $display("planar_to_packed_palette test passed");
      end else begin
         $display("planar_to_packed_palette test failed");
      end
      $finish;
   end

endmodule
